// ===== rtl/breath_interval_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// breath_interval_classifier_defines
// assertion macros used by the checker file of the breath interval classifier
// ----------------------------------------------------------------------------
`ifndef BREATH_INTERVAL_CLASSIFIER_DEFINES_SVH
`define BREATH_INTERVAL_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define BIC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bic check failed: same-cycle implication");

// next-cycle implication
`define BIC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bic check failed: next-cycle implication");

`endif

// ===== rtl/bic_pkg.sv =====
// ----------------------------------------------------------------------------
// bic_pkg
// types, constants and helper functions of the breath interval classifier
// ----------------------------------------------------------------------------
package bic_pkg;

  localparam int CAL_SAMPLES = 100;
  localparam int CNT_W       = 7;
  localparam int P_W         = 24;
  localparam int T_W         = 32;
  localparam int SUM_W       = 32;
  localparam int MAG_W       = 30;
  localparam int LIM_W       = 16;
  localparam int CNT_OUT_W   = 16;
  localparam int SUM3_W      = T_W + 2;
  localparam int DATA_W      = 56;

  localparam logic [CNT_W-1:0] CAL_COUNT = CNT_W'(CAL_SAMPLES);

  // reciprocal for the calibration mean, exact for magnitudes below 2**MAG_W
  localparam int MEAN_SHIFT = MAG_W + $clog2(CAL_SAMPLES);
  localparam longint MEAN_MULT_L = ((64'd1 << MEAN_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam logic [31:0] MEAN_MULT = 32'(MEAN_MULT_L);
  localparam int PROD_W = MAG_W + 32;

  // divide by three: radix-4 digits spread over pipeline stages
  localparam int DIV_STAGES  = 3;
  localparam int DIV_DIGITS  = 6;
  localparam int DIV_CHUNK_W = 2 * DIV_DIGITS;
  localparam int DIV_W       = DIV_STAGES * DIV_CHUNK_W;
  localparam int LAST        = DIV_STAGES - 1;

  localparam logic [LIM_W-1:0] SHORT_RESET = 16'd1000;
  localparam logic [LIM_W-1:0] LONG_RESET  = 16'd2000;

  localparam logic REG_SHORT = 1'b0;
  localparam logic REG_LONG  = 1'b1;

  typedef enum logic [1:0] {
    RATE_GOOD   = 2'd0,
    RATE_MEDIUM = 2'd1,
    RATE_BAD    = 2'd2
  } rating_t;

  typedef struct packed {
    logic                 run;
    logic                 detect;
    logic                 calibrating;
    logic                 inhaling;
    logic [CNT_OUT_W-1:0] inhale_count;
    logic [SUM3_W-1:0]    sum3;
  } bic_item_t;

  typedef struct packed {
    bic_item_t        item;
    logic [DIV_W-1:0] quo;
    logic [1:0]       rem;
  } bic_div_t;

  typedef struct packed {
    logic [1:0]             rem;
    logic [DIV_CHUNK_W-1:0] quo;
  } div_chunk_t;

  function automatic div_chunk_t div3_chunk(input logic [1:0] rem_in,
                                            input logic [DIV_CHUNK_W-1:0] chunk);
    div_chunk_t res;
    logic [3:0] v;
    logic [1:0] r;
    int         i;
    res = '0;
    r   = rem_in;
    for (i = DIV_DIGITS - 1; i >= 0; i--) begin
      v = {r, chunk[2*i +: 2]};
      if (v >= 4'd9) begin
        res.quo[2*i +: 2] = 2'd3;
        r = 2'(v - 4'd9);
      end else if (v >= 4'd6) begin
        res.quo[2*i +: 2] = 2'd2;
        r = 2'(v - 4'd6);
      end else if (v >= 4'd3) begin
        res.quo[2*i +: 2] = 2'd1;
        r = 2'(v - 4'd3);
      end else begin
        res.quo[2*i +: 2] = 2'd0;
        r = 2'(v);
      end
    end
    res.rem = r;
    return res;
  endfunction

endpackage

// ===== rtl/bic_tail.sv =====
// ----------------------------------------------------------------------------
// bic_tail
// interval mean divide-by-three pipeline, rating and output register
// ----------------------------------------------------------------------------
module bic_tail
  import bic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bic_item_t         in_item,
  input  logic [LIM_W-1:0]  short_limit,
  input  logic [LIM_W-1:0]  long_limit,
  output logic              m_tvalid,
  input  logic              m_tready,
  // feedback, calibrating, inhaling, inhale_count, mean_interval, zero pad
  output logic [DATA_W-1:0] m_tdata
);

  bic_div_t              stg [DIV_STAGES-1];
  logic [DIV_STAGES-2:0] stg_valid;
  logic [T_W-1:0]        avg_hold;
  rating_t               rating_hold;

  bic_div_t              fd [DIV_STAGES];
  bic_div_t              nx [DIV_STAGES];
  logic [DIV_STAGES-1:0] fv;
  logic [DIV_STAGES-1:0] reg_free;
  logic [T_W-1:0]        avg_sel;
  rating_t               rate_sel;

  always_comb begin
    logic [DIV_W-1:0] dividend;
    div_chunk_t       step;
    int               k;
    fd[0]      = '0;
    fd[0].item = in_item;
    fv[0]      = in_valid;
    for (k = 1; k < DIV_STAGES; k++) begin
      fd[k] = stg[k-1];
      fv[k] = stg_valid[k-1];
    end
    for (k = 0; k < DIV_STAGES; k++) begin
      dividend = DIV_W'(fd[k].item.sum3);
      step     = div3_chunk(fd[k].rem,
                            dividend[DIV_W - (k+1)*DIV_CHUNK_W +: DIV_CHUNK_W]);
      nx[k]    = fd[k];
      nx[k].quo[DIV_W - (k+1)*DIV_CHUNK_W +: DIV_CHUNK_W] = step.quo;
      nx[k].rem = step.rem;
    end
    reg_free[LAST] = !m_tvalid || m_tready;
    for (k = LAST - 1; k >= 0; k--) begin
      reg_free[k] = !stg_valid[k] || reg_free[k+1];
    end
    in_ready = reg_free[0];
  end

  always_comb begin
    avg_sel = nx[LAST].item.detect ? nx[LAST].quo[T_W-1:0] : avg_hold;
    if (!nx[LAST].item.run) begin
      rate_sel = rating_hold;
    end else if (avg_sel < T_W'(short_limit)) begin
      rate_sel = RATE_BAD;
    end else if (avg_sel < T_W'(long_limit)) begin
      rate_sel = RATE_MEDIUM;
    end else begin
      rate_sel = RATE_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid   <= '0;
      m_tvalid    <= 1'b0;
      avg_hold    <= '0;
      rating_hold <= RATE_GOOD;
    end else begin
      for (int k = 0; k < LAST; k++) begin
        if (reg_free[k]) begin
          stg_valid[k] <= fv[k];
        end
      end
      if (reg_free[LAST]) begin
        m_tvalid <= fv[LAST];
      end
      if (reg_free[LAST] && fv[LAST]) begin
        avg_hold    <= avg_sel;
        rating_hold <= rate_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LAST; k++) begin
      if (reg_free[k] && fv[k]) begin
        stg[k] <= nx[k];
      end
    end
    if (reg_free[LAST] && fv[LAST]) begin
      m_tdata <= {4'b0, avg_sel, nx[LAST].item.inhale_count, nx[LAST].item.inhaling,
                  nx[LAST].item.calibrating, rate_sel};
    end
  end

endmodule

// ===== rtl/breath_interval_classifier.sv =====
// ----------------------------------------------------------------------------
// breath_interval_classifier
// calibrates on the first pressure samples, then detects inhales and rates
// the mean interval between them
// ----------------------------------------------------------------------------
// One sample transfer is taken per clock while the output side keeps up, and
// each gives one result via the item, divider stage and output registers.
// The detector state is updated in the cycle a sample is accepted; the mean
// of the last three intervals is divided by three across three pipeline
// stages of six radix-4 digits each, and the last stage also rates the mean
// against short_limit and long_limit. The calibration mean is taken with one
// reciprocal multiply on the sample that completes calibration.
module breath_interval_classifier
  import bic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // pressure [23:0], time_ms [55:24]
  input  logic [DATA_W-1:0] s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // feedback [1:0], calibrating [2], inhaling [3], inhale_count [19:4],
  // mean_interval [51:20], zero [55:52]
  output logic [DATA_W-1:0] m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [LIM_W-1:0]        short_limit;
  logic [LIM_W-1:0]        long_limit;
  logic [CNT_W-1:0]        sample_count, sample_count_next;
  logic                    in_calibration, in_calibration_next;
  logic                    first_pending, first_pending_next;
  logic signed [SUM_W-1:0] sum_acc, sum_acc_next;
  logic signed [P_W-1:0]   cal_min, cal_min_next;
  logic signed [P_W-1:0]   cal_max, cal_max_next;
  logic signed [P_W-1:0]   window [3];
  logic signed [P_W-1:0]   window_next [3];
  logic [T_W-1:0]          stamp_window [3];
  logic [T_W-1:0]          stamp_window_next [3];
  logic [T_W-1:0]          interval_window [3];
  logic [T_W-1:0]          interval_window_next [3];
  logic [T_W-1:0]          last_inhale, last_inhale_next;
  logic [CNT_OUT_W-1:0]    inhale_total, inhale_total_next;
  logic                    scan_inhale, scan_inhale_next;
  logic                    a_valid, a_valid_next;
  bic_item_t               a_item, a_item_next;

  logic                    tail_ready;
  logic                    s_fire;
  logic                    cfg_write;

  logic signed [P_W-1:0]   p;
  logic [T_W-1:0]          now;
  logic signed [P_W-1:0]   base_min, base_max;
  logic signed [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0]        cnt_new;
  logic                    cal_done;
  logic                    mean_neg;
  logic [MAG_W-1:0]        mean_mag;
  logic [PROD_W-1:0]       mean_prod;
  logic [P_W-1:0]          mean_q;
  logic signed [P_W-1:0]   mean;
  logic signed [P_W-1:0]   mx01, mx, mn01, mn;
  logic                    det_hit;
  logic                    scan_mid;
  logic [T_W-1:0]          i_new;
  logic [SUM3_W-1:0]       sum3;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign s_tready  = !a_valid || tail_ready;
  assign s_fire    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit <= SHORT_RESET;
      long_limit  <= LONG_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SHORT: short_limit <= pwdata[LIM_W-1:0];
        REG_LONG:  long_limit  <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SHORT: prdata = {16'b0, short_limit};
      REG_LONG:  prdata = {16'b0, long_limit};
      default:   prdata = '0;
    endcase
  end

  // calibration datapath
  always_comb begin
    p         = signed'(s_tdata[P_W-1:0]);
    now       = s_tdata[P_W +: T_W];
    base_min  = first_pending ? p : cal_min;
    base_max  = first_pending ? p : cal_max;
    sum_new   = sum_acc + SUM_W'(p);
    cnt_new   = sample_count + CNT_W'(1);
    cal_done  = (cnt_new == CAL_COUNT);
    mean_neg  = sum_new[SUM_W-1];
    mean_mag  = MAG_W'(mean_neg ? -sum_new : sum_new);
    mean_prod = PROD_W'(mean_mag) * PROD_W'(MEAN_MULT);
    mean_q    = P_W'(mean_prod >> MEAN_SHIFT);
    mean      = mean_neg ? signed'(-mean_q) : signed'(mean_q);
  end

  // detector datapath
  always_comb begin
    mx01     = (window[1] > window[2]) ? window[1] : window[2];
    mx       = (mx01 > p) ? mx01 : p;
    mn01     = (window[1] < window[2]) ? window[1] : window[2];
    mn       = (mn01 < p) ? mn01 : p;
    det_hit  = !scan_inhale && (mx <= cal_min);
    scan_mid = scan_inhale || det_hit;
    i_new    = now - last_inhale;
    sum3     = SUM3_W'(interval_window[1]) + SUM3_W'(interval_window[2]) + SUM3_W'(i_new);
  end

  always_comb begin
    sample_count_next   = sample_count;
    in_calibration_next = in_calibration;
    first_pending_next  = first_pending;
    sum_acc_next        = sum_acc;
    cal_min_next        = cal_min;
    cal_max_next        = cal_max;
    window_next          = window;
    stamp_window_next    = stamp_window;
    interval_window_next = interval_window;
    last_inhale_next    = last_inhale;
    inhale_total_next   = inhale_total;
    scan_inhale_next    = scan_inhale;
    a_valid_next        = s_tready ? s_tvalid : a_valid;
    a_item_next         = a_item;
    if (s_fire) begin
      first_pending_next = 1'b0;
      if (in_calibration) begin
        sum_acc_next      = sum_new;
        cal_min_next      = (p < base_min) ? p : base_min;
        cal_max_next      = (p > base_max) ? p : base_max;
        sample_count_next = cnt_new;
        if (cal_done) begin
          in_calibration_next = 1'b0;
          for (int k = 0; k < 3; k++) begin
            window_next[k]          = mean;
            stamp_window_next[k]    = now;
            interval_window_next[k] = T_W'(mean);
          end
          last_inhale_next  = now;
          scan_inhale_next  = 1'b0;
          inhale_total_next = '0;
        end
      end else begin
        window_next[0]          = window[1];
        window_next[1]          = window[2];
        window_next[2]          = p;
        stamp_window_next[0]    = stamp_window[1];
        stamp_window_next[1]    = stamp_window[2];
        stamp_window_next[2]    = now;
        interval_window_next[0] = interval_window[1];
        interval_window_next[1] = interval_window[2];
        interval_window_next[2] = i_new;
        if (det_hit) begin
          last_inhale_next = stamp_window[1];
          if (inhale_total != {CNT_OUT_W{1'b1}}) begin
            inhale_total_next = inhale_total + CNT_OUT_W'(1);
          end
        end
        scan_inhale_next = scan_mid && !(mn >= cal_max);
      end
      a_item_next.run          = !in_calibration;
      a_item_next.detect       = !in_calibration && det_hit;
      a_item_next.calibrating  = in_calibration_next;
      a_item_next.inhaling     = scan_inhale_next;
      a_item_next.inhale_count = inhale_total_next;
      a_item_next.sum3         = sum3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      in_calibration <= 1'b1;
      first_pending  <= 1'b1;
      sum_acc        <= '0;
      last_inhale    <= '0;
      inhale_total   <= '0;
      scan_inhale    <= 1'b0;
      a_valid        <= 1'b0;
    end else begin
      sample_count   <= sample_count_next;
      in_calibration <= in_calibration_next;
      first_pending  <= first_pending_next;
      sum_acc        <= sum_acc_next;
      last_inhale    <= last_inhale_next;
      inhale_total   <= inhale_total_next;
      scan_inhale    <= scan_inhale_next;
      a_valid        <= a_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cal_min         <= cal_min_next;
    cal_max         <= cal_max_next;
    window          <= window_next;
    stamp_window    <= stamp_window_next;
    interval_window <= interval_window_next;
    a_item          <= a_item_next;
  end

  bic_tail u_tail (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (a_valid),
    .in_ready    (tail_ready),
    .in_item     (a_item),
    .short_limit (short_limit),
    .long_limit  (long_limit),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// ===== rtl/bic_checker.sv =====
// ----------------------------------------------------------------------------
// bic_checker
// port-level checks of the breath interval classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "breath_interval_classifier_defines.svh"

module bic_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  logic        cal_done_seen;
  logic [15:0] last_count;
  logic        m_xfer;

  assign m_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_done_seen <= 1'b0;
      last_count    <= '0;
    end else if (m_xfer) begin
      if (!m_tdata[2]) begin
        cal_done_seen <= 1'b1;
      end
      last_count <= m_tdata[19:4];
    end
  end

  // stalled result transfer holds
  `BIC_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // feedback code is one of good, medium, bad
  `BIC_ASSERT_IMP(a_fb_code, clk, rst, m_tvalid, m_tdata[1:0] != 2'd3)
  // calibration never restarts
  `BIC_ASSERT_IMP(a_cal_once, clk, rst, m_tvalid && cal_done_seen, !m_tdata[2])
  // nothing is counted or rated while calibrating
  `BIC_ASSERT_IMP(a_cal_quiet, clk, rst, m_tvalid && m_tdata[2], m_tdata[51:0] == 52'd4)
  // inhale count never goes down
  `BIC_ASSERT_IMP(a_count_mono, clk, rst, m_tvalid, m_tdata[19:4] >= last_count)

endmodule

bind breath_interval_classifier bic_checker u_bic_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
